>>> rtl/countdown_stopwatch_seven_segment_unit_assert.svh
// ============================================================================
// Countdown stopwatch assertion macros
// Clocked property wrappers for the stopwatch top level.
// ============================================================================
`ifndef COUNTDOWN_STOPWATCH_SEVEN_SEGMENT_UNIT_ASSERT_SVH
`define COUNTDOWN_STOPWATCH_SEVEN_SEGMENT_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CDSW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stopwatch same-cycle check failed");

// next-cycle implication, checked outside reset
`define CDSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stopwatch next-cycle check failed");

`endif

>>> rtl/cdsw_pkg.sv
// ============================================================================
// Countdown stopwatch package
// Request codes, item type, saturation to 99 and seven-segment lookup.
// ============================================================================
package cdsw_pkg;

    localparam int unsigned FieldW   = 7;
    localparam int unsigned ReqW     = 3;
    localparam int unsigned MaskW    = 3;
    localparam int unsigned SegW     = 8;
    localparam int unsigned PairW    = 2 * SegW;

    localparam logic [FieldW-1:0] MaxPair   = 7'd99;
    localparam logic [FieldW-1:0] MaxSecond = 7'd59;
    localparam logic [FieldW-1:0] MinCount  = 7'd0;
    localparam logic [13:0]       DivTenMul = 14'd103;

    localparam logic [MaskW-1:0] MaskMin = 3'b100;
    localparam logic [MaskW-1:0] MaskSec = 3'b010;
    localparam logic [MaskW-1:0] MaskHun = 3'b001;

    typedef enum logic [ReqW-1:0] {
        REQ_TICK     = 3'd0,
        REQ_STOP     = 3'd1,
        REQ_RUN      = 3'd2,
        REQ_DISP_ON  = 3'd3,
        REQ_DISP_OFF = 3'd4,
        REQ_SET      = 3'd5
    } t_req;

    typedef struct packed {
        logic [ReqW-1:0]   req_type;
        logic [MaskW-1:0]  set_mask;
        logic [FieldW-1:0] set_minutes;
        logic [FieldW-1:0] set_seconds;
        logic [FieldW-1:0] set_hundredths;
    } t_item;

    function automatic logic [FieldW-1:0] sat99(input logic [FieldW-1:0] v);
        return (v > MaxPair) ? MaxPair : v;
    endfunction

    function automatic logic [SegW-1:0] seg_lut(input logic [3:0] d);
        logic [SegW-1:0] pat;
        unique case (d)
            4'd0:    pat = 8'b00111111;
            4'd1:    pat = 8'b00000110;
            4'd2:    pat = 8'b01011011;
            4'd3:    pat = 8'b01001111;
            4'd4:    pat = 8'b01100110;
            4'd5:    pat = 8'b01101101;
            4'd6:    pat = 8'b01111101;
            4'd7:    pat = 8'b00000111;
            4'd8:    pat = 8'b01111111;
            4'd9:    pat = 8'b01100111;
            default: pat = 8'b00000000;
        endcase
        return pat;
    endfunction

endpackage

>>> rtl/cdsw_seg.sv
// ============================================================================
// Stopwatch digit-pair encoder
// Split a two-digit value into tens and ones and map both to segments.
// ============================================================================
module cdsw_seg (
    input  logic [cdsw_pkg::FieldW-1:0] i_value,
    output logic [cdsw_pkg::PairW-1:0]  o_pattern
);

    logic [cdsw_pkg::FieldW-1:0] value_sat;
    logic [13:0]                 prod;
    logic [3:0]                  tens;
    logic [3:0]                  ones;

    always_comb begin
        value_sat = cdsw_pkg::sat99(i_value);
        // divide by ten via reciprocal, exact below 179
        prod      = 14'(value_sat) * cdsw_pkg::DivTenMul;
        tens      = prod[13:10];
        ones      = 4'(value_sat - 7'(tens) * 7'd10);
        o_pattern = {cdsw_pkg::seg_lut(tens), cdsw_pkg::seg_lut(ones)};
    end

endmodule

>>> rtl/cdsw_in_reg.sv
// ============================================================================
// Stopwatch input register
// Capture one request transfer and hold it until the core takes it.
// ============================================================================
module cdsw_in_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [cdsw_pkg::ReqW-1:0]   i_req_type,
    input  logic [cdsw_pkg::MaskW-1:0]  i_set_mask,
    input  logic [cdsw_pkg::FieldW-1:0] i_set_minutes,
    input  logic [cdsw_pkg::FieldW-1:0] i_set_seconds,
    input  logic [cdsw_pkg::FieldW-1:0] i_set_hundredths,
    input  logic                        i_advance,
    output logic                        o_item_valid,
    output cdsw_pkg::t_item             o_item
);

    logic            r_valid;
    logic            n_valid;
    cdsw_pkg::t_item r_item;
    logic            load;

    always_comb begin
        o_stall = r_valid && !i_advance;
        load    = i_valid && !o_stall;
        n_valid = load || (r_valid && !i_advance);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= '{req_type:       i_req_type,
                        set_mask:       i_set_mask,
                        set_minutes:    i_set_minutes,
                        set_seconds:    i_set_seconds,
                        set_hundredths: i_set_hundredths};
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

>>> rtl/cdsw_core.sv
// ============================================================================
// Stopwatch core
// Apply one request to the time, run and display state; hold the result.
// ============================================================================
module cdsw_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    input  cdsw_pkg::t_item             i_item,
    output logic                        o_advance,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [31:0]                 o_hex_low,
    output logic [15:0]                 o_hex_high,
    output logic [cdsw_pkg::FieldW-1:0] o_minutes_now,
    output logic [cdsw_pkg::FieldW-1:0] o_seconds_now,
    output logic [cdsw_pkg::FieldW-1:0] o_hundredths_now,
    output logic                        o_is_running,
    output logic                        o_reached_zero
);

    logic [cdsw_pkg::FieldW-1:0] r_min, r_sec, r_hun;
    logic [cdsw_pkg::FieldW-1:0] n_min, n_sec, n_hun;
    logic                        r_run, n_run;
    logic                        r_disp, n_disp;
    logic [47:0]                 r_latch, n_latch;
    logic                        r_out_valid, n_out_valid;

    logic                        load;
    logic                        was_zero;
    logic                        now_zero;
    logic                        refresh;
    logic                        clear;
    logic [cdsw_pkg::PairW-1:0]  pat_min, pat_sec, pat_hun;

    assign o_advance = !r_out_valid || !i_stall;
    assign load      = i_item_valid && o_advance;
    assign was_zero  = (r_min == cdsw_pkg::MinCount) && (r_sec == cdsw_pkg::MinCount)
                    && (r_hun == cdsw_pkg::MinCount);

    always_comb begin
        n_min   = r_min;
        n_sec   = r_sec;
        n_hun   = r_hun;
        n_run   = r_run;
        n_disp  = r_disp;
        refresh = 1'b0;
        clear   = 1'b0;
        unique case (cdsw_pkg::t_req'(i_item.req_type))
            cdsw_pkg::REQ_TICK: begin
                if (r_run) begin
                    if (r_hun != cdsw_pkg::MinCount) begin
                        n_hun = r_hun - 7'd1;
                    end else if (r_sec != cdsw_pkg::MinCount) begin
                        n_sec = r_sec - 7'd1;
                        n_hun = cdsw_pkg::MaxPair;
                    end else if (r_min != cdsw_pkg::MinCount) begin
                        n_min = r_min - 7'd1;
                        n_sec = cdsw_pkg::MaxSecond;
                        n_hun = cdsw_pkg::MaxPair;
                    end
                    refresh = r_disp;
                end
            end
            cdsw_pkg::REQ_STOP: begin
                n_run = 1'b0;
            end
            cdsw_pkg::REQ_RUN: begin
                n_run = 1'b1;
            end
            cdsw_pkg::REQ_DISP_ON: begin
                n_disp  = 1'b1;
                refresh = !r_run || was_zero;
            end
            cdsw_pkg::REQ_DISP_OFF: begin
                n_disp = 1'b0;
                clear  = 1'b1;
            end
            cdsw_pkg::REQ_SET: begin
                if ((i_item.set_mask & cdsw_pkg::MaskMin) != '0) begin
                    n_min = cdsw_pkg::sat99(i_item.set_minutes);
                end
                if ((i_item.set_mask & cdsw_pkg::MaskSec) != '0) begin
                    n_sec = cdsw_pkg::sat99(i_item.set_seconds);
                end
                if ((i_item.set_mask & cdsw_pkg::MaskHun) != '0) begin
                    n_hun = cdsw_pkg::sat99(i_item.set_hundredths);
                end
                refresh = !r_run || was_zero;
            end
            default: begin
            end
        endcase
        now_zero = (n_min == cdsw_pkg::MinCount) && (n_sec == cdsw_pkg::MinCount)
                && (n_hun == cdsw_pkg::MinCount);
        // stop on reaching zero; restart when a set leaves zero
        if ((i_item.req_type == cdsw_pkg::REQ_TICK) && r_run && now_zero) begin
            n_run = 1'b0;
        end
        if ((i_item.req_type == cdsw_pkg::REQ_SET) && was_zero && !now_zero) begin
            n_run = 1'b1;
        end
    end

    cdsw_seg u_seg_min (.i_value(n_min), .o_pattern(pat_min));
    cdsw_seg u_seg_sec (.i_value(n_sec), .o_pattern(pat_sec));
    cdsw_seg u_seg_hun (.i_value(n_hun), .o_pattern(pat_hun));

    always_comb begin
        priority if (clear) begin
            n_latch = '0;
        end else if (refresh) begin
            n_latch = {pat_min, pat_sec, pat_hun};
        end else begin
            n_latch = r_latch;
        end
        n_out_valid = o_advance ? i_item_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= cdsw_pkg::MaxSecond;
            r_sec       <= cdsw_pkg::MaxSecond;
            r_hun       <= cdsw_pkg::MaxPair;
            r_run       <= 1'b1;
            r_disp      <= 1'b0;
            r_latch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (load) begin
                r_min   <= n_min;
                r_sec   <= n_sec;
                r_hun   <= n_hun;
                r_run   <= n_run;
                r_disp  <= n_disp;
                r_latch <= n_latch;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_hex_low        = r_latch[31:0];
    assign o_hex_high       = r_latch[47:32];
    assign o_minutes_now    = r_min;
    assign o_seconds_now    = r_sec;
    assign o_hundredths_now = r_hun;
    assign o_is_running     = r_run;
    assign o_reached_zero   = was_zero;

endmodule

>>> rtl/countdown_stopwatch_seven_segment_unit.sv
// A request passes the input register, then the state register, before its result is valid.
// Throughput: 1 request per cycle when not stalled; time, run, display update once per transfer.
// The state register doubles as the result register and holds while the output is stalled.
// Reset (synchronous, active low): time 59:59.99, running, display off, all segments off.
// ============================================================================
// Countdown stopwatch with seven-segment output
// Top level: input register, stopwatch core and result handshake.
// ============================================================================
`include "countdown_stopwatch_seven_segment_unit_assert.svh"

module countdown_stopwatch_seven_segment_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [cdsw_pkg::ReqW-1:0]   i_req_type,
    input  logic [cdsw_pkg::MaskW-1:0]  i_set_mask,
    input  logic [cdsw_pkg::FieldW-1:0] i_set_minutes,
    input  logic [cdsw_pkg::FieldW-1:0] i_set_seconds,
    input  logic [cdsw_pkg::FieldW-1:0] i_set_hundredths,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [31:0]                 o_hex_low,
    output logic [15:0]                 o_hex_high,
    output logic [cdsw_pkg::FieldW-1:0] o_minutes_now,
    output logic [cdsw_pkg::FieldW-1:0] o_seconds_now,
    output logic [cdsw_pkg::FieldW-1:0] o_hundredths_now,
    output logic                        o_is_running,
    output logic                        o_reached_zero
);

    logic            item_valid;
    cdsw_pkg::t_item item;
    logic            advance;
    logic            fields_in_range;
    logic            seg_spare_clear;

    cdsw_in_reg u_in_reg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_set_mask       (i_set_mask),
        .i_set_minutes    (i_set_minutes),
        .i_set_seconds    (i_set_seconds),
        .i_set_hundredths (i_set_hundredths),
        .i_advance        (advance),
        .o_item_valid     (item_valid),
        .o_item           (item)
    );

    cdsw_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (item_valid),
        .i_item           (item),
        .o_advance        (advance),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_hex_low        (o_hex_low),
        .o_hex_high       (o_hex_high),
        .o_minutes_now    (o_minutes_now),
        .o_seconds_now    (o_seconds_now),
        .o_hundredths_now (o_hundredths_now),
        .o_is_running     (o_is_running),
        .o_reached_zero   (o_reached_zero)
    );

    assign fields_in_range = (o_minutes_now <= cdsw_pkg::MaxPair)
                          && (o_seconds_now <= cdsw_pkg::MaxPair)
                          && (o_hundredths_now <= cdsw_pkg::MaxPair);
    assign seg_spare_clear = !o_hex_low[7] && !o_hex_low[15] && !o_hex_low[23]
                          && !o_hex_low[31] && !o_hex_high[7] && !o_hex_high[15];

    `CDSW_ASSERT_NOW(a_stall_needs_item, o_stall, item_valid && o_valid && i_stall)
    `CDSW_ASSERT_NOW(a_fields_in_range, 1'b1, fields_in_range)
    `CDSW_ASSERT_NOW(a_seg_msb_clear, 1'b1, seg_spare_clear)
    `CDSW_ASSERT_NEXT(a_held_item_kept, item_valid && o_valid && i_stall, item_valid)

endmodule
